// File: design/sm83alu_pkg.sv
// ----------------------------------------------------------------------------
// sm83alu_pkg
// Operation codes, flag positions, constants and request/response types for
// the SM83 ALU and flag unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sm83alu_pkg;

    localparam int OP_W   = 4;
    localparam int WORD_W = 16;
    localparam int FLAG_W = 4;

    localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
    localparam logic [OP_W-1:0] OP_ADC   = 4'd1;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd2;
    localparam logic [OP_W-1:0] OP_SBC   = 4'd3;
    localparam logic [OP_W-1:0] OP_INC   = 4'd4;
    localparam logic [OP_W-1:0] OP_DEC   = 4'd5;
    localparam logic [OP_W-1:0] OP_RLC   = 4'd6;
    localparam logic [OP_W-1:0] OP_RRC   = 4'd7;
    localparam logic [OP_W-1:0] OP_RL    = 4'd8;
    localparam logic [OP_W-1:0] OP_RR    = 4'd9;
    localparam logic [OP_W-1:0] OP_DAA   = 4'd10;
    localparam logic [OP_W-1:0] OP_CPL   = 4'd11;
    localparam logic [OP_W-1:0] OP_SCF   = 4'd12;
    localparam logic [OP_W-1:0] OP_CCF   = 4'd13;
    localparam logic [OP_W-1:0] OP_ADD16 = 4'd14;

    // flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [7:0] DAA_LO_FIX  = 8'h06;
    localparam logic [7:0] DAA_HI_FIX  = 8'h60;
    localparam logic [7:0] DAA_A_MAX   = 8'h99;
    localparam logic [3:0] DAA_NIB_MAX = 4'h9;
    localparam logic [3:0] NIB_ALL     = 4'hF;

    typedef struct packed {
        logic [OP_W-1:0]   req_type;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
        logic [FLAG_W-1:0] flags_in;
        logic              prefix_cb;
    } t_alu_req;

    typedef struct packed {
        logic [WORD_W-1:0] result_value;
        logic [FLAG_W-1:0] flags_out;
    } t_alu_rsp;

endpackage

`default_nettype wire

// File: design/sm83alu_core.sv
// ----------------------------------------------------------------------------
// sm83alu_core
// Combinational datapath: adders, rotates, decimal adjust and flag logic.
// ----------------------------------------------------------------------------
`default_nettype none

module sm83alu_core (
    input  var sm83alu_pkg::t_alu_req i_req,
    output sm83alu_pkg::t_alu_rsp     o_rsp
);

    always_comb begin
        logic [7:0]  a;
        logic [7:0]  b;
        logic        c;
        logic        cin;
        logic [8:0]  wide8;
        logic [4:0]  nib;
        logic [16:0] wide16;
        logic [12:0] low12;
        logic [7:0]  r8;
        logic [7:0]  corr;
        logic        cout;
        logic [3:0]  f;
        logic [15:0] res;

        a      = i_req.operand_a[7:0];
        b      = i_req.operand_b[7:0];
        c      = i_req.flags_in[sm83alu_pkg::FLAG_C];
        cin    = 1'b0;
        wide8  = '0;
        nib    = '0;
        wide16 = '0;
        low12  = '0;
        r8     = a;
        corr   = '0;
        cout   = c;
        f      = i_req.flags_in;
        res    = {8'h00, a};

        unique case (i_req.req_type)
            sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_ADC: begin
                cin   = (i_req.req_type == sm83alu_pkg::OP_ADC) & c;
                wide8 = {1'b0, a} + {1'b0, b} + {8'h00, cin};
                nib   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
                r8    = wide8[7:0];
                f     = {r8 == 8'h00, 1'b0, nib[4], wide8[8]};
                res   = {8'h00, r8};
            end
            sm83alu_pkg::OP_SUB, sm83alu_pkg::OP_SBC: begin
                // borrow shows as the sign bit of the widened difference
                cin   = (i_req.req_type == sm83alu_pkg::OP_SBC) & c;
                wide8 = {1'b0, a} - {1'b0, b} - {8'h00, cin};
                nib   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cin};
                r8    = wide8[7:0];
                f     = {r8 == 8'h00, 1'b1, nib[4], wide8[8]};
                res   = {8'h00, r8};
            end
            sm83alu_pkg::OP_INC: begin
                r8  = b + 8'd1;
                f   = {r8 == 8'h00, 1'b0, r8[3:0] == 4'h0, c};
                res = {8'h00, r8};
            end
            sm83alu_pkg::OP_DEC: begin
                r8  = b - 8'd1;
                f   = {r8 == 8'h00, 1'b1, r8[3:0] == sm83alu_pkg::NIB_ALL, c};
                res = {8'h00, r8};
            end
            sm83alu_pkg::OP_RLC: begin
                cout = b[7];
                r8   = {b[6:0], b[7]};
                f    = {i_req.prefix_cb & (r8 == 8'h00), 2'b00, cout};
                res  = {8'h00, r8};
            end
            sm83alu_pkg::OP_RRC: begin
                cout = b[0];
                r8   = {b[0], b[7:1]};
                f    = {i_req.prefix_cb & (r8 == 8'h00), 2'b00, cout};
                res  = {8'h00, r8};
            end
            sm83alu_pkg::OP_RL: begin
                cout = b[7];
                r8   = {b[6:0], c};
                f    = {i_req.prefix_cb & (r8 == 8'h00), 2'b00, cout};
                res  = {8'h00, r8};
            end
            sm83alu_pkg::OP_RR: begin
                cout = b[0];
                r8   = {c, b[7:1]};
                f    = {i_req.prefix_cb & (r8 == 8'h00), 2'b00, cout};
                res  = {8'h00, r8};
            end
            sm83alu_pkg::OP_DAA: begin
                if (!i_req.flags_in[sm83alu_pkg::FLAG_N]) begin
                    if (i_req.flags_in[sm83alu_pkg::FLAG_H] ||
                        (a[3:0] > sm83alu_pkg::DAA_NIB_MAX)) begin
                        corr = corr | sm83alu_pkg::DAA_LO_FIX;
                    end
                    if (c || (a > sm83alu_pkg::DAA_A_MAX)) begin
                        corr = corr | sm83alu_pkg::DAA_HI_FIX;
                        cout = 1'b1;
                    end
                    r8 = a + corr;
                end else begin
                    // subtract mode keeps the incoming carry
                    if (i_req.flags_in[sm83alu_pkg::FLAG_H]) begin
                        corr = corr | sm83alu_pkg::DAA_LO_FIX;
                    end
                    if (c) begin
                        corr = corr | sm83alu_pkg::DAA_HI_FIX;
                    end
                    r8 = a - corr;
                end
                f   = {r8 == 8'h00, i_req.flags_in[sm83alu_pkg::FLAG_N], 1'b0, cout};
                res = {8'h00, r8};
            end
            sm83alu_pkg::OP_CPL: begin
                r8  = ~a;
                f   = {i_req.flags_in[sm83alu_pkg::FLAG_Z], 2'b11, c};
                res = {8'h00, r8};
            end
            sm83alu_pkg::OP_SCF: begin
                f = {i_req.flags_in[sm83alu_pkg::FLAG_Z], 3'b001};
            end
            sm83alu_pkg::OP_CCF: begin
                f = {i_req.flags_in[sm83alu_pkg::FLAG_Z], 2'b00, ~c};
            end
            sm83alu_pkg::OP_ADD16: begin
                wide16 = {1'b0, i_req.operand_a} + {1'b0, i_req.operand_b};
                low12  = {1'b0, i_req.operand_a[11:0]} + {1'b0, i_req.operand_b[11:0]};
                f      = {i_req.flags_in[sm83alu_pkg::FLAG_Z], 1'b0, low12[12], wide16[16]};
                res    = wide16[15:0];
            end
            default: begin
                // unused code: pass A through, flags unchanged
                f   = i_req.flags_in;
                res = {8'h00, a};
            end
        endcase

        o_rsp.result_value = res;
        o_rsp.flags_out    = f;
    end

endmodule

`default_nettype wire

// File: design/sm83_alu_with_flags.sv
// ----------------------------------------------------------------------------
// sm83_alu_with_flags
// Beats pass from input to output through an input register and a result
// register, with the ALU datapath between them. Throughput: one beat per cycle
// unless the output stalls. Output stalls propagate to s_axis_tready only when
// both stages are full. Reset empties both stages; no data is held across reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sm83_alu_with_flags (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] operand_a, [31:16] operand_b, [35:32] flags_in, [39:36] zero
    input  wire  [39:0] s_axis_tdata,
    // [3:0] req_type, [4] prefix_cb
    input  wire  [4:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [15:0] result_value, [19:16] flags_out, [23:20] zero
    output logic [23:0] m_axis_tdata
);

    sm83alu_pkg::t_alu_req r_req;
    sm83alu_pkg::t_alu_req n_req;
    sm83alu_pkg::t_alu_rsp r_rsp;
    sm83alu_pkg::t_alu_rsp core_rsp;
    logic                  r_in_valid;
    logic                  r_out_valid;
    logic                  out_free;
    logic                  in_free;

    assign out_free = !r_out_valid || m_axis_tready;
    assign in_free  = !r_in_valid || out_free;

    assign n_req.req_type  = s_axis_tuser[3:0];
    assign n_req.prefix_cb = s_axis_tuser[4];
    assign n_req.operand_a = s_axis_tdata[15:0];
    assign n_req.operand_b = s_axis_tdata[31:16];
    assign n_req.flags_in  = s_axis_tdata[35:32];

    sm83alu_core u_core (
        .i_req (r_req),
        .o_rsp (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && s_axis_tvalid) begin
            r_req <= n_req;
        end
        // advance a computed beat into the result register
        if (out_free && r_in_valid) begin
            r_rsp <= core_rsp;
        end
    end

    assign s_axis_tready = in_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'h0, r_rsp.flags_out, r_rsp.result_value};

endmodule

`default_nettype wire
